@@ rtl/sts_pkg.sv @@
// Shared types and constants of the stabilisation trajectory smoother.
package sts_pkg;

  localparam int DATA_W  = 32;
  localparam int TRAJ_W  = 48;
  localparam int NCH     = 3;
  localparam int TDATA_W = NCH * DATA_W;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0] RADIUS_RESET = 4'd15;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic sum_run;
    logic div_load;
    logic div_run;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
  } dp_status_t;

endpackage

@@ rtl/sts_ctrl.sv @@
// Controller state machine of the stabilisation trajectory smoother.
module sts_ctrl
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = in_tvalid && (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_run = 1'b1;
        if (status.sum_done) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (status.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

@@ rtl/sts_dp.sv @@
// Datapath of the stabilisation trajectory smoother: trajectory, window memory, divider.
module sts_dp
  import sts_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_tuser,
  input  logic [TDATA_W-1:0] in_tdata,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic [TDATA_W-1:0] out_tdata
);

  localparam int WIN_DEPTH = MAX_RADIUS + 1;
  localparam int PW        = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W     = TRAJ_W + CNT_W;
  localparam int R_W       = SUM_W + 2;
  localparam int IT_W      = $clog2(SUM_W + 1);
  localparam int LW        = (CNT_W > CFG_W + 1) ? CNT_W : CFG_W + 1;

  logic [CFG_W-1:0]         radius_r;
  logic [TRAJ_W-1:0]        traj_r    [NCH];
  logic [TRAJ_W-1:0]        traj_nxt  [NCH];
  logic [CNT_W-1:0]         fill_r, fill_nxt, fill_base;
  logic [PW-1:0]            ptr_r, ptr_nxt, slot;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [LW-1:0]            rad_ext, lim, fill_ext;
  logic [DATA_W-1:0]        in_r      [NCH];
  logic [NCH*TRAJ_W-1:0]    wr_word;
  logic [NCH*TRAJ_W-1:0]    win_mem   [WIN_DEPTH];
  logic [NCH*TRAJ_W-1:0]    rd_data_r;
  logic [CNT_W-1:0]         rd_left_r;
  logic [PW-1:0]            rd_addr_r;
  logic                     rdv_r;
  logic                     rd_issue;
  logic [SUM_W-1:0]         acc_r     [NCH];
  logic [R_W-1:0]           diff_r    [NCH];
  logic                     neg_r     [NCH];
  logic [CNT_W-1:0]         rem_r     [NCH];
  logic [SUM_W-1:0]         quo_r     [NCH];
  logic [IT_W-1:0]          it_r;
  logic [CNT_W:0]           trial     [NCH];
  logic                     qbit      [NCH];
  logic [SUM_W-1:0]         mag       [NCH];
  logic [R_W-1:0]           avg       [NCH];
  logic [R_W-1:0]           res       [NCH];
  logic [R_W-DATA_W:0]      res_hi    [NCH];
  logic [DATA_W-1:0]        sat       [NCH];
  logic [DATA_W-1:0]        out_r     [NCH];

  assign slot      = in_tuser ? '0 : ptr_r;
  assign ptr_nxt   = (slot == PW'(WIN_DEPTH - 1)) ? '0 : slot + 1'b1;
  assign fill_base = in_tuser ? '0 : fill_r;
  assign fill_nxt  = (fill_base == CNT_W'(WIN_DEPTH)) ? fill_base : fill_base + 1'b1;
  assign rad_ext   = LW'(radius_r);
  assign lim       = (rad_ext >= LW'(WIN_DEPTH)) ? LW'(WIN_DEPTH) : rad_ext + 1'b1;
  assign fill_ext  = LW'(fill_nxt);
  assign cnt_nxt   = CNT_W'((fill_ext < lim) ? fill_ext : lim);
  assign rd_issue  = cmd.sum_run && (rd_left_r != '0);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      traj_nxt[c] = (in_tuser ? '0 : traj_r[c]) +
                    {{(TRAJ_W-DATA_W){in_tdata[c*DATA_W+DATA_W-1]}},
                     in_tdata[c*DATA_W +: DATA_W]};
      wr_word[c*TRAJ_W +: TRAJ_W] = traj_nxt[c];
      trial[c] = {rem_r[c], quo_r[c][SUM_W-1]};
      qbit[c]  = (trial[c] >= {1'b0, cnt_r});
      mag[c]   = (acc_r[c][SUM_W-1] ? (~acc_r[c] + 1'b1) : acc_r[c]) + SUM_W'(cnt_r >> 1);
      avg[c]   = neg_r[c] ? (~R_W'(quo_r[c]) + 1'b1) : R_W'(quo_r[c]);
      res[c]   = diff_r[c] + avg[c];
      res_hi[c] = res[c][R_W-1:DATA_W-1];
      if ((&res_hi[c]) || !(|res_hi[c])) sat[c] = res[c][DATA_W-1:0];
      else if (res[c][R_W-1]) sat[c] = {1'b1, {(DATA_W-1){1'b0}}};
      else sat[c] = {1'b0, {(DATA_W-1){1'b1}}};
      out_tdata[c*DATA_W +: DATA_W] = out_r[c];
    end
  end

  assign status.sum_done = (rd_left_r == '0) && !rdv_r;
  assign status.div_done = (it_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RESET;
      fill_r    <= '0;
      ptr_r     <= '0;
      rd_left_r <= '0;
      rdv_r     <= 1'b0;
      it_r      <= '0;
      for (int c = 0; c < NCH; c++) traj_r[c] <= '0;
    end else begin
      if (cfg_wr_en) radius_r <= cfg_wr_data;
      rdv_r <= rd_issue;
      if (cmd.accept) begin
        fill_r    <= fill_nxt;
        ptr_r     <= ptr_nxt;
        rd_left_r <= cnt_nxt;
        for (int c = 0; c < NCH; c++) traj_r[c] <= traj_nxt[c];
      end else if (rd_issue) begin
        rd_left_r <= rd_left_r - 1'b1;
      end
      if (cmd.div_load) it_r <= IT_W'(SUM_W);
      else if (cmd.div_run && (it_r != '0)) it_r <= it_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) win_mem[slot] <= wr_word;
    if (rd_issue) rd_data_r <= win_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_r     <= cnt_nxt;
      rd_addr_r <= slot;
    end else if (rd_issue) begin
      rd_addr_r <= (rd_addr_r == '0) ? PW'(WIN_DEPTH - 1) : rd_addr_r - 1'b1;
    end
    for (int c = 0; c < NCH; c++) begin
      diff_r[c] <= {{(R_W-DATA_W){in_r[c][DATA_W-1]}}, in_r[c]} -
                   {{(R_W-TRAJ_W){traj_r[c][TRAJ_W-1]}}, traj_r[c]};
      if (cmd.accept) begin
        in_r[c]  <= in_tdata[c*DATA_W +: DATA_W];
        acc_r[c] <= '0;
      end else if (rdv_r) begin
        acc_r[c] <= acc_r[c] +
                    {{(SUM_W-TRAJ_W){rd_data_r[c*TRAJ_W+TRAJ_W-1]}},
                     rd_data_r[c*TRAJ_W +: TRAJ_W]};
      end
      if (cmd.div_load) begin
        neg_r[c] <= acc_r[c][SUM_W-1];
        quo_r[c] <= mag[c];
        rem_r[c] <= '0;
      end else if (cmd.div_run && (it_r != '0)) begin
        quo_r[c] <= {quo_r[c][SUM_W-2:0], qbit[c]};
        rem_r[c] <= qbit[c] ? CNT_W'(trial[c] - {1'b0, cnt_r}) : CNT_W'(trial[c]);
      end
      if (cmd.out_load) out_r[c] <= sat[c];
    end
  end

endmodule

@@ rtl/stabilization_trajectory_smoother_top.sv @@
// Top level of the stabilisation trajectory smoother.
// One frame at a time: an accepted transaction sums its cnt window points, then divides the sum by cnt,
// where cnt is the window count and the quotient has SUM_W = 48 + clog2(MAX_RADIUS + 2) bits (53 by default).
// The window memory is read one point a cycle and the divider retires one bit a cycle.
// A new transaction can be taken in the cycle after the result is registered.
// Synchronous active-low reset clears the trajectory and window fill and sets the radius to 15.
module stabilization_trajectory_smoother_top
  import sts_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,   // window_radius
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,      // frame_dx, frame_dy, frame_da
  input  logic               in_tuser,      // clip_start
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata      // corr_dx, corr_dy, corr_da
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  sts_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_tdata   (out_tdata)
  );

endmodule

@@ rtl/sts_checker.sv @@
// Port-level assertion checker of the stabilisation trajectory smoother, with its bind.
module sts_checker
  import sts_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  a_reset_state: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("Block not idle after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("Second transaction accepted while one is in progress.");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("Result appeared while the block was idle.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or was dropped.");

endmodule

bind stabilization_trajectory_smoother_top sts_checker u_sts_checker (.*);
